/* rtl/pai_pkg.sv */
// ----------------------------------------------------------------------------
// pai_pkg
// Shared types, constants and helpers of the primitive assembly indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package pai_pkg;

    localparam int MAX_POLYGON_CORNERS = 32;
    localparam int INDEX_BITS          = 24;
    localparam int POLY_AW             = $clog2(MAX_POLYGON_CORNERS);
    localparam int CNT_W               = $clog2(MAX_POLYGON_CORNERS + 1);
    localparam int SETPOS_W            = 16;

    localparam logic [INDEX_BITS-1:0] COUNT_MAX = {INDEX_BITS{1'b1}};

    localparam logic [2:0] MODE_TRIANGLES  = 3'd0;
    localparam logic [2:0] MODE_TRI_STRIP  = 3'd1;
    localparam logic [2:0] MODE_FAN        = 3'd2;
    localparam logic [2:0] MODE_QUADS      = 3'd3;
    localparam logic [2:0] MODE_QUAD_STRIP = 3'd4;
    localparam logic [2:0] MODE_POLYGON    = 3'd5;

    typedef struct packed {
        logic [INDEX_BITS-1:0] n;
        logic [INDEX_BITS-1:0] t;
        logic [INDEX_BITS-1:0] v;
    } t_corner;

    typedef struct packed {
        logic             load;
        logic             poly;
        logic             last;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic             poly;
        logic [CNT_W-1:0] count;
    } t_status;

    function automatic logic [INDEX_BITS-1:0] sat_inc(input logic [INDEX_BITS-1:0] x);
        sat_inc = (x == COUNT_MAX) ? x : x + 1'b1;
    endfunction

endpackage

`default_nettype wire

/* rtl/pai_ram.sv */
// ----------------------------------------------------------------------------
// pai_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pai_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/pai_ctrl.sv */
// ----------------------------------------------------------------------------
// pai_ctrl
// Sequencer that takes a vertex and then streams the corners of its face.
// ----------------------------------------------------------------------------
`default_nettype none

module pai_ctrl
    import pai_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    input  wire logic    i_m_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_LOAD, S_OUT} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_cnt;
    logic             r_poly;
    logic             w_final;

    assign w_final    = (r_idx == r_cnt - 1'b1);
    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;
    assign o_m_tvalid = (r_state == S_OUT);

    assign o_cmd.load = (r_state == S_LOAD);
    assign o_cmd.poly = r_poly;
    assign o_cmd.last = w_final;
    assign o_cmd.idx  = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_poly  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && i_status.count != '0) begin
                        r_cnt   <= i_status.count;
                        r_idx   <= '0;
                        r_poly  <= i_status.poly;
                        r_state <= i_status.poly ? S_READ : S_LOAD;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        if (w_final) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= r_poly ? S_READ : S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/pai_dp.sv */
// ----------------------------------------------------------------------------
// pai_dp
// Index counters, corner window, polygon store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pai_dp
    import pai_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    input  wire logic       i_accept,
    input  wire logic [2:0] i_mode,
    input  wire logic       i_first,
    input  wire logic       i_last,
    input  wire logic       i_has_normal,
    input  wire logic       i_has_texcoord,
    input  wire t_cmd       i_cmd,
    output t_status         o_status,
    output logic [95:0]     o_m_tdata,
    output logic            o_m_tlast,
    output logic            o_m_tuser
);

    logic                  r_flip;
    logic [INDEX_BITS-1:0] r_vc, r_nc, r_tc, r_gc;
    logic [SETPOS_W-1:0]   r_setpos;
    logic                  r_par;
    logic [1:0]            r_wf;
    logic                  r_trunc;
    t_corner               r_anchor;
    t_corner               r_win [3];
    t_corner               r_face [4];
    logic [INDEX_BITS-1:0] r_grp;
    logic                  r_ftrunc;
    t_corner               r_out;
    logic                  r_out_last;
    logic                  r_out_tr;

    logic [INDEX_BITS-1:0] n_vc, n_nc, n_tc, n_gc;
    logic [SETPOS_W-1:0]   n_setpos;
    logic                  n_par;
    logic [1:0]            n_wf;
    logic                  n_trunc;
    t_corner               n_anchor;
    t_corner               n_win [3];
    t_corner               n_face [4];
    logic [INDEX_BITS-1:0] n_grp;
    logic                  n_face_we;

    logic                  w_fs;
    logic [SETPOS_W-1:0]   w_sp;
    logic [SETPOS_W-1:0]   w_posm1;
    logic [1:0]            w_wf0;
    t_corner               w_c;
    logic                  w_pwe;
    logic                  w_rev;
    t_corner               w_rdata;

    assign w_posm1 = w_sp - 1'b1;

    always_comb begin
        n_vc      = r_vc;
        n_nc      = r_nc;
        n_tc      = r_tc;
        n_gc      = r_gc;
        n_par     = r_par;
        n_wf      = r_wf;
        n_trunc   = r_trunc;
        n_anchor  = r_anchor;
        n_win     = r_win;
        n_face    = r_face;
        n_grp     = r_grp;
        n_face_we = 1'b0;
        w_pwe     = 1'b0;
        w_rev     = 1'b0;
        o_status  = '0;

        w_fs  = i_first || (r_setpos == '0);
        w_wf0 = w_fs ? 2'd0 : r_wf;
        n_wf  = w_wf0;
        if (w_fs) begin
            n_par   = 1'b0;
            n_trunc = 1'b0;
        end
        w_sp = w_fs ? '0 : r_setpos;
        if (w_sp != {SETPOS_W{1'b1}}) begin
            w_sp = w_sp + 1'b1;
        end

        n_vc  = sat_inc(r_vc);
        w_c.v = n_vc;
        w_c.n = '0;
        w_c.t = '0;
        if (i_has_normal) begin
            n_nc  = sat_inc(r_nc);
            w_c.n = n_nc;
        end
        if (i_has_texcoord) begin
            n_tc  = sat_inc(r_tc);
            w_c.t = n_tc;
        end

        if (((i_mode == MODE_QUADS || i_mode == MODE_QUAD_STRIP) && w_sp == 16'd4) ||
            ((i_mode == MODE_TRIANGLES || i_mode == MODE_TRI_STRIP || i_mode == MODE_FAN)
             && w_sp == 16'd3)) begin
            n_gc = sat_inc(r_gc);
        end
        n_grp = n_gc;

        unique case (i_mode)
            MODE_TRIANGLES: begin
                if (w_wf0 >= 2'd2) begin
                    n_face[0] = r_win[0];
                    n_face[1] = r_win[1];
                    n_face[2] = w_c;
                    n_face_we = 1'b1;
                    o_status.count = CNT_W'(3);
                    n_wf = 2'd0;
                end else begin
                    n_win[w_wf0] = w_c;
                    n_wf = w_wf0 + 1'b1;
                end
            end
            MODE_TRI_STRIP: begin
                if (w_wf0 >= 2'd2) begin
                    if (r_flip) begin
                        w_rev = n_par;
                        n_par = ~n_par;
                    end
                    n_face[0] = w_rev ? w_c : r_win[0];
                    n_face[1] = r_win[1];
                    n_face[2] = w_rev ? r_win[0] : w_c;
                    n_face_we = 1'b1;
                    o_status.count = CNT_W'(3);
                    n_win[0] = r_win[1];
                    n_win[1] = w_c;
                    n_wf = 2'd2;
                end else begin
                    n_win[w_wf0] = w_c;
                    n_wf = w_wf0 + 1'b1;
                end
            end
            MODE_FAN: begin
                if (w_wf0 == 2'd0) begin
                    n_anchor = w_c;
                    n_wf = 2'd1;
                end else if (w_wf0 == 2'd1) begin
                    n_win[0] = w_c;
                    n_wf = 2'd2;
                end else begin
                    n_face[0] = r_anchor;
                    n_face[1] = r_win[0];
                    n_face[2] = w_c;
                    n_face_we = 1'b1;
                    o_status.count = CNT_W'(3);
                    n_win[0] = w_c;
                    n_wf = 2'd2;
                end
            end
            MODE_QUADS: begin
                if (w_wf0 == 2'd3) begin
                    n_face[0] = r_win[0];
                    n_face[1] = r_win[1];
                    n_face[2] = r_win[2];
                    n_face[3] = w_c;
                    n_face_we = 1'b1;
                    o_status.count = CNT_W'(4);
                    n_wf = 2'd0;
                end else begin
                    n_win[w_wf0] = w_c;
                    n_wf = w_wf0 + 1'b1;
                end
            end
            MODE_QUAD_STRIP: begin
                if (w_wf0 == 2'd3) begin
                    n_face[0] = r_win[0];
                    n_face[1] = r_win[1];
                    n_face[2] = w_c;
                    n_face[3] = r_win[2];
                    n_face_we = 1'b1;
                    o_status.count = CNT_W'(4);
                    n_win[0] = r_win[2];
                    n_win[1] = w_c;
                    n_wf = 2'd2;
                end else begin
                    n_win[w_wf0] = w_c;
                    n_wf = w_wf0 + 1'b1;
                end
            end
            MODE_POLYGON: begin
                if (w_sp <= SETPOS_W'(MAX_POLYGON_CORNERS)) begin
                    w_pwe = 1'b1;
                end else begin
                    n_trunc = 1'b1;
                end
                if (i_last) begin
                    o_status.poly = 1'b1;
                    o_status.count = (w_sp < SETPOS_W'(MAX_POLYGON_CORNERS)) ?
                                     w_sp[CNT_W-1:0] : CNT_W'(MAX_POLYGON_CORNERS);
                    if (w_sp >= 16'd3) begin
                        n_gc  = sat_inc(r_gc);
                        n_grp = n_gc;
                    end else begin
                        n_grp = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        n_setpos = i_last ? '0 : w_sp;
    end

    pai_ram #(
        .WIDTH ($bits(t_corner)),
        .DEPTH (MAX_POLYGON_CORNERS)
    ) u_poly_ram (
        .i_clk   (i_clk),
        .i_we    (i_accept && w_pwe),
        .i_waddr (w_posm1[POLY_AW-1:0]),
        .i_wdata (w_c),
        .i_raddr (i_cmd.idx[POLY_AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip   <= 1'b0;
            r_vc     <= '0;
            r_nc     <= '0;
            r_tc     <= '0;
            r_gc     <= '0;
            r_setpos <= '0;
            r_par    <= 1'b0;
            r_wf     <= '0;
            r_trunc  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_flip <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_vc     <= n_vc;
                r_nc     <= n_nc;
                r_tc     <= n_tc;
                r_gc     <= n_gc;
                r_setpos <= n_setpos;
                r_par    <= n_par;
                r_wf     <= n_wf;
                r_trunc  <= n_trunc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_anchor <= n_anchor;
            r_win    <= n_win;
            r_grp    <= n_grp;
            r_ftrunc <= n_trunc;
            if (n_face_we) begin
                r_face <= n_face;
            end
        end
        if (i_cmd.load) begin
            r_out      <= i_cmd.poly ? w_rdata : r_face[i_cmd.idx[1:0]];
            r_out_last <= i_cmd.last;
            r_out_tr   <= i_cmd.poly && r_ftrunc;
        end
    end

    assign o_m_tdata = {r_grp, r_out.n, r_out.t, r_out.v};
    assign o_m_tlast = r_out_last;
    assign o_m_tuser = r_out_tr;

endmodule

`default_nettype wire

/* rtl/primitive_assembly_indexer_unit.sv */
// ----------------------------------------------------------------------------
// primitive_assembly_indexer_unit
// Indexes vertices and assembles them into faces streamed corner by corner.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         one vertex: mode, set marks, attribute flags
//  m_axis    out        one face corner: indices, group, last, truncated
//  cfg       in         flip_strips write
//
// A vertex is taken when the block is idle. Each triangle or quad corner then
// passes a load state and an output state; a polygon corner a read state first,
// set by the registered read of the polygon store. A vertex that completes no
// face lets the next vertex follow in the next cycle. A stalled output holds
// the block. Reset is synchronous and needs no clearing pass.
`default_nettype none

module primitive_assembly_indexer_unit
    import pai_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,  // first_of_set, has_normal, has_texcoord
    input  wire logic        i_s_tlast,  // last_of_set
    input  wire logic [2:0]  i_s_tuser,  // prim_mode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [95:0]      o_m_tdata,  // vertex, texcoord, normal, group index
    output logic             o_m_tlast,  // last_corner
    output logic             o_m_tuser   // truncated
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_accept;

    assign w_accept = i_s_tvalid && o_s_tready;

    pai_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pai_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (w_accept),
        .i_mode         (i_s_tuser),
        .i_first        (i_s_tdata[0]),
        .i_last         (i_s_tlast),
        .i_has_normal   (i_s_tdata[1]),
        .i_has_texcoord (i_s_tdata[2]),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_m_tdata      (o_m_tdata),
        .o_m_tlast      (o_m_tlast),
        .o_m_tuser      (o_m_tuser)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while a corner is pending");

    a_idle_after_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast && i_m_tready) |=> o_s_tready)
        else $error("block not idle after final corner");

    a_trunc_poly: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> w_cmd.poly)
        else $error("truncated flag on a non-polygon face");

    a_vertex_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !w_cmd.poly) |-> (o_m_tdata[23:0] != 24'd0))
        else $error("zero vertex index on a face corner");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Primitive assembly indexer testbench
// Streams vertex requests into the indexer and checks every face corner that
// comes out against an in-bench model of the indexing and face assembly. A
// short table of directed vertex sets comes first, then random sets with
// strip flipping on and off; both streams idle at random bar the last phase.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import pai_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam int         RANDOM_VERTICES = 444;
    localparam int         EXP_DEPTH = 256;

    typedef logic [INDEX_BITS-1:0] t_idx;

    typedef struct {
        t_idx v;
        t_idx t;
        t_idx n;
    } t_vtx;

    typedef struct {
        t_idx v;
        t_idx t;
        t_idx n;
        t_idx g;
        logic lastc;
        logic trunc;
    } t_face_corner;

    typedef struct {
        logic [2:0] mode;
        logic       first;
        logic       last;
        logic       hn;
        logic       ht;
        int         corners;
    } t_vertex_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic        i_s_tlast = 1'b0;
    logic [2:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [95:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;

    // Model state.
    logic  flip_strips;
    t_idx  vertex_count, normal_count, texcoord_count, group_count;
    int    set_pos, window_fill;
    logic  strip_odd, poly_dropped;
    t_vtx  fan_pivot;
    t_vtx  window [3];
    t_vtx  poly_corners [MAX_POLYGON_CORNERS];

    t_face_corner exp_fifo [EXP_DEPTH];
    int  exp_wr = 0;
    int  exp_rd = 0;
    int  errors = 0;
    bit  quiet = 1'b0;

    always #1 i_clk = ~i_clk;

    primitive_assembly_indexer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int expected_count();
        return exp_wr - exp_rd;
    endfunction

    function automatic t_idx bump(input t_idx x);
        return (x == COUNT_MAX) ? x : x + 1'b1;
    endfunction

    function automatic void add_corner(input t_vtx c, input t_idx g, input logic lastc,
                                       input logic trunc);
        t_face_corner fc;
        fc.v = c.v;
        fc.t = c.t;
        fc.n = c.n;
        fc.g = g;
        fc.lastc = lastc;
        fc.trunc = trunc;
        exp_fifo[exp_wr % EXP_DEPTH] = fc;
        exp_wr++;
    endfunction

    function automatic void add_triangle(input t_vtx a, input t_vtx b, input t_vtx c);
        add_corner(a, group_count, 1'b0, 1'b0);
        add_corner(b, group_count, 1'b0, 1'b0);
        add_corner(c, group_count, 1'b1, 1'b0);
    endfunction

    function automatic void add_quad(input t_vtx a, input t_vtx b, input t_vtx c,
                                     input t_vtx d);
        add_corner(a, group_count, 1'b0, 1'b0);
        add_corner(b, group_count, 1'b0, 1'b0);
        add_corner(c, group_count, 1'b0, 1'b0);
        add_corner(d, group_count, 1'b1, 1'b0);
    endfunction

    function automatic int assemble_vertex(input logic [2:0] mode, input logic first,
                                           input logic last, input logic hn,
                                           input logic ht);
        t_vtx c;
        int   start_wr, thr, cnt;
        t_idx grp;
        start_wr = exp_wr;
        if (first || set_pos == 0) begin
            set_pos = 0;
            window_fill = 0;
            strip_odd = 1'b0;
            poly_dropped = 1'b0;
        end
        vertex_count = bump(vertex_count);
        c.v = vertex_count;
        c.n = '0;
        c.t = '0;
        if (hn) begin
            normal_count = bump(normal_count);
            c.n = normal_count;
        end
        if (ht) begin
            texcoord_count = bump(texcoord_count);
            c.t = texcoord_count;
        end
        if (set_pos < 16'hFFFF) set_pos++;
        thr = (mode == MODE_QUADS || mode == MODE_QUAD_STRIP) ? 4 : 3;
        if (mode <= MODE_QUAD_STRIP && set_pos == thr) group_count = bump(group_count);
        case (mode)
            MODE_TRIANGLES: begin
                if (window_fill >= 2) begin
                    add_triangle(window[0], window[1], c);
                    window_fill = 0;
                end else begin
                    window[window_fill++] = c;
                end
            end
            MODE_TRI_STRIP: begin
                if (window_fill >= 2) begin
                    if (flip_strips && strip_odd) add_triangle(c, window[1], window[0]);
                    else add_triangle(window[0], window[1], c);
                    if (flip_strips) strip_odd = ~strip_odd;
                    window[0] = window[1];
                    window[1] = c;
                    window_fill = 2;
                end else begin
                    window[window_fill++] = c;
                end
            end
            MODE_FAN: begin
                if (window_fill == 0) begin
                    fan_pivot = c;
                    window_fill = 1;
                end else if (window_fill == 1) begin
                    window[0] = c;
                    window_fill = 2;
                end else begin
                    add_triangle(fan_pivot, window[0], c);
                    window[0] = c;
                    window_fill = 2;
                end
            end
            MODE_QUADS: begin
                if (window_fill >= 3) begin
                    add_quad(window[0], window[1], window[2], c);
                    window_fill = 0;
                end else begin
                    window[window_fill++] = c;
                end
            end
            MODE_QUAD_STRIP: begin
                if (window_fill >= 3) begin
                    add_quad(window[0], window[1], c, window[2]);
                    window[0] = window[2];
                    window[1] = c;
                    window_fill = 2;
                end else begin
                    window[window_fill++] = c;
                end
            end
            MODE_POLYGON: begin
                if (set_pos <= MAX_POLYGON_CORNERS) poly_corners[set_pos-1] = c;
                else poly_dropped = 1'b1;
                if (last) begin
                    cnt = (set_pos < MAX_POLYGON_CORNERS) ? set_pos : MAX_POLYGON_CORNERS;
                    grp = '0;
                    if (set_pos >= 3) begin
                        group_count = bump(group_count);
                        grp = group_count;
                    end
                    for (int i = 0; i < cnt; i++)
                        add_corner(poly_corners[i], grp, i + 1 == cnt, poly_dropped);
                end
            end
            default: ;
        endcase
        if (last) set_pos = 0;
        return exp_wr - start_wr;
    endfunction

    task automatic send_vertex(input logic [2:0] mode, input logic first, input logic last,
                               input logic hn, input logic ht, input int corners);
        int made;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, ht, hn, first};
        i_s_tlast  <= last;
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        made = assemble_vertex(mode, first, last, hn, ht);
        if (corners >= 0 && made != corners)
            report_mismatch($sformatf("mode %0d vertex gave %0d corners, expected %0d",
                                      mode, made, corners));
    endtask

    task automatic settle_and_write(input logic value);
        i_s_tvalid <= 1'b0;
        while (expected_count() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        flip_strips = value;
    endtask

    // Receive side stalls.
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_face_corner e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_count() == 0) begin
                report_mismatch($sformatf("unexpected corner v=%0d", o_m_tdata[23:0]));
            end else begin
                e = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_m_tdata[23:0] !== e.v || o_m_tdata[47:24] !== e.t ||
                    o_m_tdata[71:48] !== e.n || o_m_tdata[95:72] !== e.g ||
                    o_m_tlast !== e.lastc || o_m_tuser !== e.trunc)
                    report_mismatch($sformatf(
                        "corner v/t/n/g/l/tr got %0d/%0d/%0d/%0d/%b/%b exp %0d/%0d/%0d/%0d/%b/%b",
                        o_m_tdata[23:0], o_m_tdata[47:24], o_m_tdata[71:48],
                        o_m_tdata[95:72], o_m_tlast, o_m_tuser,
                        e.v, e.t, e.n, e.g, e.lastc, e.trunc));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("primitive_assembly_indexer_unit regression: fail");
        $finish;
    end

    initial begin
        t_vertex_row rows [$];
        int sent, len, phase, dice;
        logic [2:0] mode;
        logic closed, first, last;

        flip_strips = 1'b0;
        vertex_count = '0;
        normal_count = '0;
        texcoord_count = '0;
        group_count = '0;
        set_pos = 0;
        window_fill = 0;
        strip_odd = 1'b0;
        poly_dropped = 1'b0;

        rows = '{
            '{MODE_TRIANGLES,  1, 0, 0, 0,  0}, '{MODE_TRIANGLES,  0, 0, 1, 1,  0},
            '{MODE_TRIANGLES,  0, 1, 1, 1,  3},
            '{MODE_TRI_STRIP,  1, 0, 1, 0,  0}, '{MODE_TRI_STRIP,  0, 0, 0, 1,  0},
            '{MODE_TRI_STRIP,  0, 0, 1, 1,  3}, '{MODE_TRI_STRIP,  0, 1, 0, 0,  3},
            '{MODE_FAN,        1, 0, 1, 1,  0}, '{MODE_FAN,        0, 0, 1, 1,  0},
            '{MODE_FAN,        0, 0, 1, 1,  3}, '{MODE_FAN,        0, 1, 1, 1,  3},
            '{MODE_QUADS,      1, 0, 0, 0,  0}, '{MODE_QUADS,      0, 0, 0, 0,  0},
            '{MODE_QUADS,      0, 0, 1, 0,  0}, '{MODE_QUADS,      0, 1, 0, 1,  4},
            '{MODE_QUAD_STRIP, 1, 0, 1, 1,  0}, '{MODE_QUAD_STRIP, 0, 0, 1, 1,  0},
            '{MODE_QUAD_STRIP, 0, 0, 1, 1,  0}, '{MODE_QUAD_STRIP, 0, 0, 1, 1,  4},
            '{MODE_QUAD_STRIP, 0, 0, 1, 1,  0}, '{MODE_QUAD_STRIP, 0, 1, 1, 1,  4},
            '{MODE_POLYGON,    1, 0, 1, 0,  0}, '{MODE_POLYGON,    0, 0, 0, 1,  0},
            '{MODE_POLYGON,    0, 1, 1, 1,  3},
            '{MODE_SPARE7,     1, 1, 1, 1,  0},
            '{MODE_POLYGON,    1, 0, 0, 0,  0}, '{MODE_POLYGON,    0, 1, 0, 0,  2}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 1'b0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;

        foreach (rows[i])
            send_vertex(rows[i].mode, rows[i].first, rows[i].last, rows[i].hn, rows[i].ht,
                        rows[i].corners);

        sent = 0;
        closed = 1'b1;
        for (phase = 0; phase < 3; phase++) begin
            settle_and_write(phase != 1);
            closed = 1'b1;
            // One overlong polygon per phase to force truncation.
            for (int k = 0; k < 36; k++) begin
                send_vertex(MODE_POLYGON, k == 0, k == 35, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), -1);
                sent++;
            end
            if (phase == 2) quiet = 1'b1;
            while (sent < (phase + 1) * RANDOM_VERTICES / 3) begin
                dice = $urandom_range(0, 19);
                if (dice == 0) mode = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
                else mode = 3'($urandom_range(0, 5));
                if (mode == MODE_POLYGON)
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                      : $urandom_range(3, 9);
                else
                    len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    first = (k == 0) && (!closed || $urandom_range(0, 3) != 0);
                    last  = (k == len - 1) && ($urandom_range(0, 7) != 0);
                    send_vertex(mode, first, last, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), -1);
                    sent++;
                end
                closed = last;
            end
        end

        i_s_tvalid <= 1'b0;
        while (expected_count() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("primitive_assembly_indexer_unit regression: pass");
        end else begin
            $display("primitive_assembly_indexer_unit regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
